// File: sv/wcip_pkg.sv
// shared types and constants of the weighted complex inner product block
package wcip_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int TRUNC_BITS  = 16;

  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_wgt;
    logic do_acc;
  } cmd_t;

  typedef struct packed {
    logic last_q;
    logic out_blocked;
  } status_t;

endpackage

// File: sv/weighted_complex_inner_product_core.sv
// weighted complex conjugate dot product: streams sum of w * a * conj(b)
//
// input channel: in_valid/in_ready with a_re, a_im, b_re, b_im (signed
// Q1.15), weight (unsigned Q0.16) and last. a new word is taken only once
// the previous one is through: the sequencer walks load, product, weighting and
// accumulate steps, each holding one register stage, and in_ready is high
// only between words. each weighted product is floored by 16 bits and added
// into saturating ACC_BITS accumulators.
// output channel: out_valid/out_ready with sum_re, sum_im and saturated.
// a word with last set produces one result, registered from its accumulate step;
// the accumulators and the clip flag then clear for the next vector.
// the result sits in an output register, so the next vector's words are taken
// while it waits; only a further word with last stalls in its accumulate step
// until the receiver has taken the pending result.
// reset (rst, synchronous) clears the accumulators, the clip flag, the
// sequencer and out_valid.
module weighted_complex_inner_product_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] a_re,
  input  logic signed [SAMPLE_BITS-1:0] a_im,
  input  logic signed [SAMPLE_BITS-1:0] b_re,
  input  logic signed [SAMPLE_BITS-1:0] b_im,
  input  logic [wcip_pkg::WEIGHT_BITS-1:0] weight,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ACC_BITS-1:0]    sum_re,
  output logic signed [ACC_BITS-1:0]    sum_im,
  output logic                          saturated
);

  wcip_pkg::cmd_t    cmd;
  wcip_pkg::status_t status;

  wcip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wcip_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .weight    (weight),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sum_re    (sum_re),
    .sum_im    (sum_im),
    .saturated (saturated)
  );

endmodule

// File: sv/wcip_ctrl.sv
// sequencer for the load, multiply, weight and accumulate steps
module wcip_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wcip_pkg::status_t status,
  output wcip_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_WGT  = 2'd2;
  localparam logic [1:0] S_ACC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_WGT;
      end
      S_WGT: begin
        cmd.do_wgt = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        // a closing word waits until the output register is free
        if (!(status.last_q && status.out_blocked)) begin
          cmd.do_acc = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/wcip_datapath.sv
// multipliers, weighting, saturating accumulators and output register
module wcip_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wcip_pkg::cmd_t                cmd,
  output wcip_pkg::status_t             status,
  input  logic signed [SAMPLE_BITS-1:0] a_re,
  input  logic signed [SAMPLE_BITS-1:0] a_im,
  input  logic signed [SAMPLE_BITS-1:0] b_re,
  input  logic signed [SAMPLE_BITS-1:0] b_im,
  input  logic [wcip_pkg::WEIGHT_BITS-1:0] weight,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ACC_BITS-1:0]    sum_re,
  output logic signed [ACC_BITS-1:0]    sum_im,
  output logic                          saturated
);

  localparam int P_W   = 2 * SAMPLE_BITS;
  localparam int S_W   = P_W + 1;
  localparam int WS_W  = wcip_pkg::WEIGHT_BITS + 1;
  localparam int WP_W  = S_W + WS_W;
  localparam int Q_W   = WP_W - wcip_pkg::TRUNC_BITS;
  localparam int SUM_W = ((Q_W > ACC_BITS) ? Q_W : ACC_BITS) + 1;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
  logic [wcip_pkg::WEIGHT_BITS-1:0] w_q;
  logic last_q;
  logic signed [P_W-1:0]  p_rr, p_ii, p_ir, p_ri;
  logic signed [S_W-1:0]  re_sum, im_sum;
  logic signed [WS_W-1:0] w_s;
  logic signed [WP_W-1:0] re_w, im_w;
  logic signed [Q_W-1:0]  q_re, q_im;
  logic signed [ACC_BITS-1:0] acc_re, acc_im;
  logic clip_seen;
  logic [ACC_BITS:0] add_re, add_im;
  logic clip_now;

  // returns {clip, value}
  function automatic logic [ACC_BITS:0] sat_add(input logic signed [ACC_BITS-1:0] acc,
                                               input logic signed [Q_W-1:0] q);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic [ACC_BITS:0] r;
    s  = SUM_W'(acc) + SUM_W'(q);
    hi = SUM_W'(ACC_MAX);
    lo = SUM_W'(ACC_MIN);
    if (s > hi) begin
      r = {1'b1, ACC_MAX};
    end else if (s < lo) begin
      r = {1'b1, ACC_MIN};
    end else begin
      r = {1'b0, s[ACC_BITS-1:0]};
    end
    return r;
  endfunction

  assign re_sum = S_W'(p_rr) + S_W'(p_ii);
  assign im_sum = S_W'(p_ir) - S_W'(p_ri);
  assign w_s    = {1'b0, w_q};
  // arithmetic shift right: floor toward minus infinity
  assign q_re   = re_w[WP_W-1:wcip_pkg::TRUNC_BITS];
  assign q_im   = im_w[WP_W-1:wcip_pkg::TRUNC_BITS];
  assign add_re = sat_add(acc_re, q_re);
  assign add_im = sat_add(acc_im, q_im);
  assign clip_now = add_re[ACC_BITS] | add_im[ACC_BITS];

  assign status.last_q      = last_q;
  assign status.out_blocked = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_re_q <= a_re;
      a_im_q <= a_im;
      b_re_q <= b_re;
      b_im_q <= b_im;
      w_q    <= weight;
      last_q <= last;
    end
    if (cmd.do_mul) begin
      p_rr <= a_re_q * b_re_q;
      p_ii <= a_im_q * b_im_q;
      p_ir <= a_im_q * b_re_q;
      p_ri <= b_im_q * a_re_q;
    end
    if (cmd.do_wgt) begin
      re_w <= re_sum * w_s;
      im_w <= im_sum * w_s;
    end
    if (cmd.do_acc && last_q) begin
      sum_re    <= add_re[ACC_BITS-1:0];
      sum_im    <= add_im[ACC_BITS-1:0];
      saturated <= clip_seen | clip_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re    <= '0;
      acc_im    <= '0;
      clip_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_acc) begin
        if (last_q) begin
          acc_re    <= '0;
          acc_im    <= '0;
          clip_seen <= 1'b0;
        end else begin
          acc_re    <= add_re[ACC_BITS-1:0];
          acc_im    <= add_im[ACC_BITS-1:0];
          clip_seen <= clip_seen | clip_now;
        end
      end
      if (cmd.do_acc && last_q) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: bench/tb_top.sv
// self-checking bench for the weighted complex conjugate dot product core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 48;
  localparam int SHIFT    = wcip_pkg::TRUNC_BITS;
  localparam int RAND_ITEMS = 1950;
  localparam longint SUM_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint SUM_MIN = -SUM_MAX - 64'sd1;

  typedef enum int {PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH, PH_BACKLOG} pace_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a_re;
    logic signed [SAMPLE_W-1:0] a_im;
    logic signed [SAMPLE_W-1:0] b_re;
    logic signed [SAMPLE_W-1:0] b_im;
    logic [wcip_pkg::WEIGHT_BITS-1:0] weight;
    logic last;
  } elem_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum_re;
    logic signed [ACC_W-1:0] sum_im;
    logic saturated;
  } sums_t;

  class conj_dot_scoreboard;
    longint acc_re;
    longint acc_im;
    bit     clip_seen;
    sums_t  pending_sums[$];
    int     mismatches;

    function new();
      acc_re = 0;
      acc_im = 0;
      clip_seen = 0;
      mismatches = 0;
    endfunction

    function longint clamp_add(longint acc, longint q);
      if (q > 0 && acc > SUM_MAX - q) begin
        clip_seen = 1;
        return SUM_MAX;
      end
      if (q < 0 && acc < SUM_MIN - q) begin
        clip_seen = 1;
        return SUM_MIN;
      end
      return acc + q;
    endfunction

    // weighted a * conj(b), floored by the truncation shift, into the sums
    function void note_element(elem_t e);
      longint ar, ai, br, bi, w;
      sums_t  res;
      ar = longint'(e.a_re);
      ai = longint'(e.a_im);
      br = longint'(e.b_re);
      bi = longint'(e.b_im);
      w  = longint'({48'd0, e.weight});
      acc_re = clamp_add(acc_re, ((ar * br + ai * bi) * w) >>> SHIFT);
      acc_im = clamp_add(acc_im, ((ai * br - bi * ar) * w) >>> SHIFT);
      if (e.last) begin
        res.sum_re    = acc_re[ACC_W-1:0];
        res.sum_im    = acc_im[ACC_W-1:0];
        res.saturated = clip_seen;
        pending_sums.push_back(res);
        acc_re = 0;
        acc_im = 0;
        clip_seen = 0;
      end
    endfunction

    function void check_result(sums_t got);
      sums_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: sum_re %0d sum_im %0d saturated %0d",
                 $time, got.sum_re, got.sum_im, got.saturated);
        return;
      end
      want = pending_sums.pop_front();
      if (got.sum_re !== want.sum_re) begin
        mismatches++;
        $display("%0t: sum_re expected %0d actual %0d", $time, want.sum_re, got.sum_re);
      end
      if (got.sum_im !== want.sum_im) begin
        mismatches++;
        $display("%0t: sum_im expected %0d actual %0d", $time, want.sum_im, got.sum_im);
      end
      if (got.saturated !== want.saturated) begin
        mismatches++;
        $display("%0t: saturated expected %0d actual %0d", $time, want.saturated,
                 got.saturated);
      end
    endfunction

    function int outstanding();
      return pending_sums.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] a_re = '0;
  logic signed [SAMPLE_W-1:0] a_im = '0;
  logic signed [SAMPLE_W-1:0] b_re = '0;
  logic signed [SAMPLE_W-1:0] b_im = '0;
  logic [wcip_pkg::WEIGHT_BITS-1:0] weight = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ACC_W-1:0] sum_re;
  logic signed [ACC_W-1:0] sum_im;
  logic saturated;

  conj_dot_scoreboard sums = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold = 0;

  always #1 clk = ~clk;

  weighted_complex_inner_product_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .ACC_BITS(ACC_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .a_re(a_re),
    .a_im(a_im),
    .b_re(b_re),
    .b_im(b_im),
    .weight(weight),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sum_re(sum_re),
    .sum_im(sum_im),
    .saturated(saturated)
  );

  // receiver side: long hold-off when asked, otherwise random stalls
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        sink_hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sums.check_result({sum_re, sum_im, saturated});
    end
  end

  function automatic void set_pace(pace_t p);
    case (p)
      PH_STEADY: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      PH_SRC_IDLE: begin
        src_idle_pct = 54;
        sink_stall_pct = 0;
      end
      PH_SINK_STALL: begin
        src_idle_pct = 0;
        sink_stall_pct = 54;
      end
      PH_BOTH: begin
        src_idle_pct = 14;
        sink_stall_pct = 14;
      end
      PH_BACKLOG: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
        sink_hold = 300;
      end
      default: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic elem_t make_elem(int ar, int ai, int br, int bi, int w, bit lst);
    elem_t e;
    e.a_re = ar[SAMPLE_W-1:0];
    e.a_im = ai[SAMPLE_W-1:0];
    e.b_re = br[SAMPLE_W-1:0];
    e.b_im = bi[SAMPLE_W-1:0];
    e.weight = w[15:0];
    e.last = lst;
    return e;
  endfunction

  // samples lean on the extremes now and then, else full range
  function automatic int rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return -32768;
    if (pick < 20) return 32767;
    if (pick < 25) return 0;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int rand_weight();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 65535;
    if (pick < 15) return 0;
    return $urandom_range(65535);
  endfunction

  function automatic elem_t rand_elem(bit lst);
    return make_elem(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                     rand_weight(), lst);
  endfunction

  function automatic int rand_vec_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(6, 1);
    if (pick < 95) return $urandom_range(30, 7);
    return $urandom_range(80, 31);
  endfunction

  task automatic send_element(input elem_t e);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    a_re <= e.a_re;
    a_im <= e.a_im;
    b_re <= e.b_re;
    b_im <= e.b_im;
    weight <= e.weight;
    last <= e.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sums.note_element(e);
  endtask

  initial begin
    int sent;
    int len;
    bit backlog_done;
    backlog_done = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_pace(PH_STEADY);
    // single-element vectors at the extremes
    send_element(make_elem(-32768, -32768, -32768, -32768, 65535, 1'b1));
    send_element(make_elem(32767, -32768, -32768, 32767, 65535, 1'b1));
    send_element(make_elem(32767, 32767, 32767, 32767, 65535, 1'b1));
    send_element(make_elem(-32768, 32767, 32767, -32768, 65535, 1'b1));
    send_element(make_elem(32767, 32767, -32768, -32768, 0, 1'b1));
    send_element(make_elem(0, 0, 0, 0, 0, 1'b1));
    send_element(make_elem(-1, -1, -1, -1, 65535, 1'b1));
    // tiny products: negative ones floor away from zero
    send_element(make_elem(1, 0, -1, 0, 1, 1'b1));
    send_element(make_elem(1, 0, 1, 0, 1, 1'b1));
    send_element(make_elem(0, 1, 1, 0, 1, 1'b1));
    send_element(make_elem(0, 1, -1, 0, 1, 1'b1));
    send_element(make_elem(0, 1, 0, 1, 65535, 1'b1));
    // short multi-word vectors
    send_element(make_elem(12345, -2222, 30000, 17, 40000, 1'b0));
    send_element(make_elem(-32768, 32767, 5, -5, 1, 1'b0));
    send_element(make_elem(32767, -32768, -32768, 32767, 65535, 1'b1));
    send_element(make_elem(-32768, -32768, -32768, -32768, 65535, 1'b0));
    send_element(make_elem(-32768, 32767, 32767, -32768, 65535, 1'b1));

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent < 400) set_pace(PH_STEADY);
      else if (sent < 850) set_pace(PH_SRC_IDLE);
      else if (sent < 1300) set_pace(PH_SINK_STALL);
      else if (sent < 1750) set_pace(PH_BOTH);
      else if (sent < 1800) set_pace(PH_STEADY);
      if (sent >= 1800 && !backlog_done && sink_hold == 0) begin
        // receiver held off while short vectors keep coming, so the core backs up
        backlog_done = 1'b1;
        set_pace(PH_BACKLOG);
        for (int i = 0; i < 40; i++) send_element(rand_elem($urandom_range(3) != 0));
        send_element(rand_elem(1'b1));
        sent += 41;
      end else begin
        len = rand_vec_len();
        for (int i = 0; i < len; i++) send_element(rand_elem(i == len - 1));
        sent += len;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sums.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sums.mismatches == 0 && sums.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
